// ----- rtl/ewmu_pkg.sv -----
// ----------------------------------------------------------------------------
// ewmu_pkg
// Shared types and constants of the edge weight matrix unpacker.
// ----------------------------------------------------------------------------
package ewmu_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int WEIGHT_BITS = 32;
  localparam int IDX_BITS    = 10;           // row / column index
  localparam int CNT_BITS    = 11;           // node count, holds MAX_NODES
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;

  // matrix layouts of the weight section
  typedef enum logic [1:0] {
    LAYOUT_FULL         = 2'd0,
    LAYOUT_LOWER_DIAG   = 2'd1,
    LAYOUT_UPPER_DIAG   = 2'd2,
    LAYOUT_UPPER_STRICT = 2'd3
  } layout_t;

  // section status reported with each result
  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_TOO_FEW  = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODES  = 2'd1;

  // configuration write as seen by the walker
  typedef struct packed {
    logic                     wr;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  // write command produced for one weight
  typedef struct packed {
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                mirror;
    logic                write_enable;
    status_t             status;
  } cmd_t;

  // node count clamped to 1..MAX_NODES
  function automatic logic [CNT_BITS-1:0] eff_nodes(input logic [CNT_BITS-1:0] raw);
    logic [CNT_BITS-1:0] n;
    if (raw == '0) begin
      n = CNT_BITS'(1);
    end else if (raw > CNT_BITS'(MAX_NODES)) begin
      n = CNT_BITS'(MAX_NODES);
    end else begin
      n = raw;
    end
    return n;
  endfunction

endpackage

// ----- rtl/ewmu_if.sv -----
// ----------------------------------------------------------------------------
// ewmu interfaces
// Weight input, matrix write output and configuration write channels.
// ----------------------------------------------------------------------------
interface ewmu_in_if;
  import ewmu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   section_end;
  modport source (output valid, weight, section_end, input ready);
  modport sink   (input valid, weight, section_end, output ready);
endinterface

interface ewmu_out_if;
  import ewmu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IDX_BITS-1:0]    row;
  logic [IDX_BITS-1:0]    col;
  logic [WEIGHT_BITS-1:0] value;
  logic                   write_enable;
  logic [1:0]             status;
  logic                   run_end;
  modport source (output valid, row, col, value, write_enable, status, run_end,
                  input ready);
  modport sink   (input valid, row, col, value, write_enable, status, run_end,
                  output ready);
endinterface

interface ewmu_cfg_if;
  import ewmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ewmu_walk.sv -----
// ----------------------------------------------------------------------------
// ewmu_walk
// Row/column walker: holds the configuration and section position, and
// produces the write command for the weight taken in this cycle.
// ----------------------------------------------------------------------------
module ewmu_walk (
  input  logic             clk,
  input  logic             rst,
  input  ewmu_pkg::cfg_wr_t cfg_wr,
  input  logic             step,
  input  logic             section_end,
  output ewmu_pkg::cmd_t   cmd
);
  import ewmu_pkg::*;

  layout_t             layout, layout_next;
  logic [CNT_BITS-1:0] node_count, node_count_next;
  logic [IDX_BITS-1:0] row_index, row_index_next;
  logic [IDX_BITS-1:0] col_index, col_index_next;
  logic                matrix_filled, matrix_filled_next;
  logic                overflow_seen, overflow_seen_next;

  logic [CNT_BITS-1:0] n, rs_n;
  logic [CNT_BITS-1:0] r11, c11, r_inc, c_inc, r_inc2;
  logic [CNT_BITS-1:0] adv_row, adv_col;
  logic                adv_filled;
  layout_t             rs_layout;

  // one position step in the current layout
  always_comb begin
    n      = eff_nodes(node_count);
    r11    = {1'b0, row_index};
    c11    = {1'b0, col_index};
    r_inc  = r11 + CNT_BITS'(1);
    c_inc  = c11 + CNT_BITS'(1);
    r_inc2 = r11 + CNT_BITS'(2);
    adv_row    = r11;
    adv_col    = c_inc;
    adv_filled = matrix_filled;
    unique case (layout)
      LAYOUT_FULL: begin
        if (c_inc >= n) begin
          adv_col = '0;
          adv_row = r_inc;
          adv_filled = matrix_filled | (r_inc >= n);
        end
      end
      LAYOUT_LOWER_DIAG: begin
        if (c11 >= r11) begin
          adv_col = '0;
          adv_row = r_inc;
          adv_filled = matrix_filled | (r_inc >= n);
        end
      end
      LAYOUT_UPPER_DIAG: begin
        if (c_inc >= n) begin
          adv_col = r_inc;
          adv_row = r_inc;
          adv_filled = matrix_filled | (r_inc >= n);
        end
      end
      default: begin
        if (c_inc >= n) begin
          adv_col = r_inc2;
          adv_row = r_inc;
          adv_filled = matrix_filled | (r_inc2 >= n);
        end
      end
    endcase
  end

  // command for the weight at the current position; a surplus weight
  // never mirrors
  always_comb begin
    cmd.row          = row_index;
    cmd.col          = col_index;
    cmd.mirror       = !matrix_filled && (layout != LAYOUT_FULL) &&
                       (row_index != col_index);
    cmd.write_enable = !matrix_filled;
    if (matrix_filled || overflow_seen) begin
      cmd.status = ST_TOO_MANY;
    end else if (!section_end) begin
      cmd.status = ST_RUNNING;
    end else if (adv_filled) begin
      cmd.status = ST_COMPLETE;
    end else begin
      cmd.status = ST_TOO_FEW;
    end
  end

  // next state: config restart, section end restart, or step
  always_comb begin
    layout_next     = layout;
    node_count_next = node_count;
    if (cfg_wr.wr && cfg_wr.index == CFG_LAYOUT) begin
      layout_next = layout_t'(cfg_wr.data[1:0]);
    end
    if (cfg_wr.wr && cfg_wr.index == CFG_NODES) begin
      node_count_next = cfg_wr.data;
    end
    rs_layout = layout_next;
    rs_n      = eff_nodes(node_count_next);

    row_index_next     = row_index;
    col_index_next     = col_index;
    matrix_filled_next = matrix_filled;
    overflow_seen_next = overflow_seen;

    if (cfg_wr.wr && (cfg_wr.index == CFG_LAYOUT || cfg_wr.index == CFG_NODES)) begin
      row_index_next     = '0;
      col_index_next     = (rs_layout == LAYOUT_UPPER_STRICT) ? IDX_BITS'(1) : '0;
      matrix_filled_next = (rs_layout == LAYOUT_UPPER_STRICT) && (rs_n <= CNT_BITS'(1));
      overflow_seen_next = 1'b0;
    end else if (step && section_end) begin
      row_index_next     = '0;
      col_index_next     = (layout == LAYOUT_UPPER_STRICT) ? IDX_BITS'(1) : '0;
      matrix_filled_next = (layout == LAYOUT_UPPER_STRICT) && (n <= CNT_BITS'(1));
      overflow_seen_next = 1'b0;
    end else if (step) begin
      if (matrix_filled) begin
        overflow_seen_next = 1'b1;
      end else begin
        row_index_next     = adv_row[IDX_BITS-1:0];
        col_index_next     = adv_col[IDX_BITS-1:0];
        matrix_filled_next = adv_filled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout        <= LAYOUT_FULL;
      node_count    <= CNT_BITS'(1);
      row_index     <= '0;
      col_index     <= '0;
      matrix_filled <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      layout        <= layout_next;
      node_count    <= node_count_next;
      row_index     <= row_index_next;
      col_index     <= col_index_next;
      matrix_filled <= matrix_filled_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ----- rtl/edge_weight_matrix_unpacker.sv -----
// ----------------------------------------------------------------------------
// edge_weight_matrix_unpacker
// Turns a stream of explicit edge weights into matrix write commands.
// ----------------------------------------------------------------------------
// Usage:
//   weights: one edge weight per beat, section_end on the final weight.
//   writes:  matrix write beats (row, col, value, write_enable, status,
//            run_end). A triangular weight off the diagonal gives two beats,
//            (row, col) then (col, row); run_end marks the last beat of each
//            weight. Surplus weights give one beat with write_enable low.
//   cfg:     register writes (0 layout, 1 node count), always ready; only
//            while the block is idle. A register write restarts the section.
// Output: the first write beat of an accepted weight comes from the output
//   register in the cycle after the weight is taken.
// Throughput: one weight per cycle when each gives a single beat and
//   writes.ready stays high; a mirrored weight holds the output register for
//   two beats, so the output port sets the rate at one beat per cycle.
// Reset: full matrix layout, node count 1, section at its start, output empty.
// Stall: while writes.ready is low the output register holds its beat and a
//   new weight is taken only in the cycle the last pending beat leaves.
// ----------------------------------------------------------------------------
module edge_weight_matrix_unpacker (
  input  logic         clk,
  input  logic         rst,
  ewmu_in_if.sink      weights,
  ewmu_out_if.source   writes,
  ewmu_cfg_if.sink     cfg
);
  import ewmu_pkg::*;

  cfg_wr_t cfg_wr;
  cmd_t    cmd;
  logic    take;
  logic    last_beat;

  // output register
  logic                   out_valid;
  logic                   second;
  cmd_t                   out_cmd;
  logic [WEIGHT_BITS-1:0] out_value;

  assign cfg.ready     = 1'b1;
  assign cfg_wr.wr     = cfg.valid;
  assign cfg_wr.index  = cfg.index;
  assign cfg_wr.data   = cfg.data;

  // the pending beat is the last one of its weight
  assign last_beat     = second || !out_cmd.mirror;
  assign weights.ready = !out_valid || (writes.ready && last_beat);
  assign take          = weights.valid && weights.ready;

  ewmu_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .step        (take),
    .section_end (weights.section_end),
    .cmd         (cmd)
  );

  // beat sequencing: load on accept, step to the mirrored beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      second    <= 1'b0;
    end else if (out_valid && writes.ready) begin
      out_valid <= !last_beat;
      second    <= !last_beat;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (take) begin
      out_cmd   <= cmd;
      out_value <= cmd.write_enable ? weights.weight : '0;
    end
  end

  always_comb begin
    writes.valid        = out_valid;
    writes.row          = out_cmd.write_enable ? (second ? out_cmd.col : out_cmd.row) : '0;
    writes.col          = out_cmd.write_enable ? (second ? out_cmd.row : out_cmd.col) : '0;
    writes.value        = out_value;
    writes.write_enable = out_cmd.write_enable;
    writes.status       = out_cmd.status;
    writes.run_end      = last_beat;
  end

endmodule

// ----- tb/ewmu_write_checker.sv -----
// ----------------------------------------------------------------------------
// ewmu_write_checker
// Watches the weight, write and configuration channels of the edge weight
// matrix unpacker. It keeps its own walk through the matrix, queues the write
// beats that each accepted weight should produce, and compares every
// accepted write beat with the oldest one in the queue.
// ----------------------------------------------------------------------------
module ewmu_write_checker (
  input  logic  clk,
  input  logic  rst,
  ewmu_in_if    weights,
  ewmu_out_if   writes,
  ewmu_cfg_if   cfg,
  output int    pending,
  output int    errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import ewmu_pkg::*;

  // one matrix write beat
  typedef struct packed {
    logic [IDX_BITS-1:0]    row;
    logic [IDX_BITS-1:0]    col;
    logic [WEIGHT_BITS-1:0] value;
    logic                   write_enable;
    status_t                status;
    logic                   run_end;
  } matrix_write_t;

  // shadow registers and walk position
  layout_t             layout_q;
  logic [CNT_BITS-1:0] nodes_q;
  int                  row_at;
  int                  col_at;
  logic                filled;
  logic                surplus_seen;

  matrix_write_t expected_writes[$];

  function automatic int node_limit();
    if (nodes_q == '0) return 1;
    if (nodes_q > CNT_BITS'(MAX_NODES)) return MAX_NODES;
    return int'(nodes_q);
  endfunction

  function automatic matrix_write_t make_write(input int r, input int c,
                                               input logic [WEIGHT_BITS-1:0] v,
                                               input logic we, input status_t st,
                                               input logic last);
    matrix_write_t m;
    m.row          = IDX_BITS'(r);
    m.col          = IDX_BITS'(c);
    m.value        = v;
    m.write_enable = we;
    m.status       = st;
    m.run_end      = last;
    return m;
  endfunction

  // append one beat to the expected queue
  task automatic queue_write(input matrix_write_t m);
    expected_writes.insert(expected_writes.size(), m);
  endtask

  // back to the first position of the layout
  task automatic restart_section();
    row_at       = 0;
    col_at       = (layout_q == LAYOUT_UPPER_STRICT) ? 1 : 0;
    filled       = (layout_q == LAYOUT_UPPER_STRICT) && (node_limit() <= 1);
    surplus_seen = 1'b0;
  endtask

  // step to the next position in section order
  task automatic step_position();
    int n;
    n = node_limit();
    case (layout_q)
      LAYOUT_FULL: begin
        if (col_at + 1 < n) begin
          col_at = col_at + 1;
        end else begin
          col_at = 0;
          row_at = row_at + 1;
          if (row_at >= n) filled = 1'b1;
        end
      end
      LAYOUT_LOWER_DIAG: begin
        if (col_at < row_at) begin
          col_at = col_at + 1;
        end else begin
          col_at = 0;
          row_at = row_at + 1;
          if (row_at >= n) filled = 1'b1;
        end
      end
      LAYOUT_UPPER_DIAG: begin
        if (col_at + 1 < n) begin
          col_at = col_at + 1;
        end else begin
          row_at = row_at + 1;
          col_at = row_at;
          if (row_at >= n) filled = 1'b1;
        end
      end
      default: begin
        if (col_at + 1 < n) begin
          col_at = col_at + 1;
        end else begin
          row_at = row_at + 1;
          col_at = row_at + 1;
          if (row_at + 1 >= n) filled = 1'b1;
        end
      end
    endcase
  endtask

  // queue the write beats caused by one weight
  task automatic predict_writes(input logic [WEIGHT_BITS-1:0] w, input logic last);
    int      r;
    int      c;
    logic    mirror;
    status_t st;
    if (filled) begin
      // surplus weight: no write, just the flag
      surplus_seen = 1'b1;
      queue_write(make_write(0, 0, '0, 1'b0, ST_TOO_MANY, 1'b1));
    end else begin
      r      = row_at;
      c      = col_at;
      mirror = (layout_q != LAYOUT_FULL) && (r != c);
      step_position();
      if (surplus_seen) st = ST_TOO_MANY;
      else if (!last)   st = ST_RUNNING;
      else if (filled)  st = ST_COMPLETE;
      else              st = ST_TOO_FEW;
      queue_write(make_write(r, c, w, 1'b1, st, !mirror));
      if (mirror) queue_write(make_write(c, r, w, 1'b1, st, 1'b1));
    end
    if (last) restart_section();
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("matrix write %s: expected %0d, got %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  task automatic check_write();
    matrix_write_t want;
    if (expected_writes.size() == 0) begin
      $error("matrix write beat with nothing expected: row %0d col %0d value %0h",
             writes.row, writes.col, writes.value);
      errors = errors + 1;
    end else begin
      want = expected_writes.pop_front();
      check_field("row", want.row, writes.row);
      check_field("col", want.col, writes.col);
      check_field("value", want.value, writes.value);
      check_field("write_enable", want.write_enable, writes.write_enable);
      check_field("status", want.status, writes.status);
      check_field("run_end", want.run_end, writes.run_end);
    end
  endtask

  // sample all channels at the edge; writes first, then new weights
  always @(posedge clk) begin
    if (rst) begin
      layout_q = LAYOUT_FULL;
      nodes_q  = CNT_BITS'(1);
      restart_section();
      expected_writes.delete();
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_LAYOUT) begin
          layout_q = layout_t'(cfg.data[1:0]);
          restart_section();
        end else if (cfg.index == CFG_NODES) begin
          nodes_q = cfg.data;
          restart_section();
        end
      end
      if (writes.valid && writes.ready) check_write();
      if (weights.valid && weights.ready) predict_writes(weights.weight, weights.section_end);
      pending <= expected_writes.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench top of the edge weight matrix unpacker. Drives a directed set of
// sections over all layouts and node count corners, then random sections
// (mostly complete ones, some short, long or with stray ends) under random
// configurations, with idle bursts on the weight side and stalls on the
// write side. Checking is done by ewmu_write_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ewmu_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 820;
  localparam int QUIET_AFTER = 700;
  // index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd2;

  logic clk;
  logic rst;

  ewmu_in_if  w_if ();
  ewmu_out_if o_if ();
  ewmu_cfg_if c_if ();

  int   pending;
  int   errors;
  int   items;
  int   cycles;
  int   stall_left;
  logic calm;
  logic quiet;

  // configuration as last written, for sizing sections
  layout_t cur_lay;
  int      cur_nodes;

  edge_weight_matrix_unpacker uut (
    .clk     (clk),
    .rst     (rst),
    .weights (w_if),
    .writes  (o_if),
    .cfg     (c_if)
  );

  ewmu_write_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .weights (w_if),
    .writes  (o_if),
    .cfg     (c_if),
    .pending (pending),
    .errors  (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // write side stalls in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      o_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      o_if.ready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      o_if.ready <= 1'b0;
    end else begin
      o_if.ready <= 1'b1;
    end
  end

  function automatic int section_size();
    int n;
    n = (cur_nodes == 0) ? 1 : ((cur_nodes > MAX_NODES) ? MAX_NODES : cur_nodes);
    case (cur_lay) inside
      LAYOUT_FULL:                          return n * n;
      LAYOUT_LOWER_DIAG, LAYOUT_UPPER_DIAG: return n * (n + 1) / 2;
      default:                              return n * (n - 1) / 2;
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  // one weight beat, with an optional idle burst in front
  task automatic send_weight(input logic [WEIGHT_BITS-1:0] w, input logic last);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 18);
    c_if.valid <= 1'b0;
    if (gap != 0) begin
      w_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w_if.valid       <= 1'b1;
    w_if.weight      <= w;
    w_if.section_end <= last;
    do @(posedge clk); while (!w_if.ready);
    items = items + 1;
  endtask

  // register write; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    c_if.valid <= 1'b1;
    c_if.index <= idx;
    c_if.data  <= data;
    do @(posedge clk); while (!c_if.ready);
    if (idx == CFG_LAYOUT)     cur_lay = layout_t'(data[1:0]);
    else if (idx == CFG_NODES) cur_nodes = int'(data);
  endtask

  // hold off until every expected write beat has left
  task automatic settle();
    w_if.valid <= 1'b0;
    c_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // complete, short, long or ragged section under the current setting
  task automatic run_section();
    int   need;
    int   len;
    int   kind;
    logic ragged;
    need   = section_size();
    kind   = $urandom_range(0, 9);
    ragged = 1'b0;
    if (need > 48) begin
      len = $urandom_range(1, 48);
    end else if (kind < 7) begin
      len = need;
    end else if (kind == 7) begin
      len = (need > 1) ? $urandom_range(1, need - 1) : need + 1;
    end else if (kind == 8) begin
      len = need + $urandom_range(1, 3);
    end else begin
      len    = $urandom_range(1, 8);
      ragged = 1'b1;
    end
    if (len < 1) len = 1;
    for (int i = 0; i < len; i++) begin
      send_weight(pick_weight(),
                  ragged ? ($urandom_range(0, 3) == 0) : (i == len - 1));
    end
  endtask

  initial begin
    layout_t lay_pick;
    int      nodes_pick;
    rst              <= 1'b1;
    w_if.valid       <= 1'b0;
    w_if.weight      <= '0;
    w_if.section_end <= 1'b0;
    c_if.valid       <= 1'b0;
    c_if.index       <= '0;
    c_if.data        <= '0;
    items      = 0;
    calm       = 1'b0;
    quiet      = 1'b0;
    cur_lay    = LAYOUT_FULL;
    cur_nodes  = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting, one node: fill, then surplus closing the section
    send_weight(32'h0000_0000, 1'b0);
    send_weight(32'hFFFF_FFFF, 1'b1);
    send_weight(32'h8000_0001, 1'b1);
    settle();
    // strict upper triangle of one node: the only weight is surplus
    write_reg(CFG_LAYOUT, CFG_DATA_BITS'(LAYOUT_UPPER_STRICT));
    send_weight(32'h1234_5678, 1'b1);
    settle();
    // lower triangle, three nodes, complete with mirrored writes
    write_reg(CFG_NODES, 11'd3);
    write_reg(CFG_LAYOUT, CFG_DATA_BITS'(LAYOUT_LOWER_DIAG));
    for (int i = 0; i < 6; i++) begin
      send_weight(i[0] ? 32'hAAAA_AAAA : 32'h5555_5555, i == 5);
    end
    settle();
    // upper triangle with diagonal, two nodes, one surplus at the end
    write_reg(CFG_LAYOUT, CFG_DATA_BITS'(LAYOUT_UPPER_DIAG));
    write_reg(CFG_NODES, 11'd2);
    for (int i = 0; i < 4; i++) send_weight(pick_weight(), i == 3);
    settle();
    // strict upper triangle, three nodes: section ends early
    write_reg(CFG_LAYOUT, CFG_DATA_BITS'(LAYOUT_UPPER_STRICT));
    write_reg(CFG_NODES, 11'd3);
    send_weight(32'h0000_0001, 1'b0);
    send_weight(32'h7FFF_FFFF, 1'b1);
    // a write to an unused index must not disturb an open section
    send_weight(32'hDEAD_BEEF, 1'b0);
    settle();
    write_reg(CFG_SPARE, 11'h7FF);
    send_weight(32'h0F0F_0F0F, 1'b0);
    send_weight(32'hF0F0_F0F0, 1'b1);
    settle();
    // node count zero acts as one
    write_reg(CFG_NODES, 11'd0);
    write_reg(CFG_LAYOUT, CFG_DATA_BITS'(LAYOUT_FULL));
    send_weight(32'hCAFE_F00D, 1'b1);
    settle();
    // node count above the maximum saturates; exact maximum
    write_reg(CFG_NODES, 11'h7FF);
    send_weight(pick_weight(), 1'b0);
    send_weight(pick_weight(), 1'b1);
    settle();
    write_reg(CFG_NODES, 11'(MAX_NODES));
    send_weight(pick_weight(), 1'b1);

    // random settings and sections
    while (items < ITEM_TARGET) begin
      settle();
      if (items >= QUIET_AFTER) quiet = 1'b1;
      calm     = ($urandom_range(0, 3) == 0);
      lay_pick = layout_t'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       nodes_pick = $urandom_range(0, 2047);
        1, 2:    nodes_pick = $urandom_range(7, 12);
        default: nodes_pick = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_LAYOUT, {9'($urandom), lay_pick});
        1: write_reg(CFG_NODES, 11'(nodes_pick));
        2: write_reg(CFG_SPARE, 11'($urandom));
        3: begin
          write_reg(CFG_NODES, 11'(nodes_pick));
          write_reg(CFG_LAYOUT, {9'($urandom), lay_pick});
        end
        default: begin
          write_reg(CFG_LAYOUT, {9'($urandom), lay_pick});
          write_reg(CFG_NODES, 11'(nodes_pick));
        end
      endcase
      repeat ($urandom_range(1, 4)) run_section();
    end

    // drain, then wait out any stray beats
    settle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
